/* hw/rtl/obsd_pkg.sv */
// Shared types and constants for the oriented box signed distance block.
// No dependencies; used by obsd_dp, obsd_ctrl and the top module in hw/rtl.
package obsd_pkg;

  localparam int unsigned STEP_W    = 5;
  localparam logic [4:0]  LAST_STEP = 5'd20;
  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic CFG_ACTIVE    = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [3:0] WSEL_SIZE0 = 4'd3;
  localparam logic [3:0] WSEL_ROT0  = 4'd6;
  localparam logic [3:0] WSEL_LAST  = 4'd14;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        box_slot;
    logic [3:0]        word_select;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         result_box;
    logic signed [31:0] distance;
    logic               is_last;
    logic signed [31:0] min_distance;
    logic [3:0]         min_box;
    logic               no_boxes;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_LD, OP_MUL, OP_CLAMP, OP_FACE, OP_SQ, OP_FIN
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EMPTY, ST_RUN, ST_WAIT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] i;
    logic [1:0] j;
  } step_dec_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] i;
    logic [1:0] j;
    logic       start_query;
    logic       write_word;
    logic       emit_empty;
    logic       is_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic wrote;
    logic sqrt_busy;
  } dp_status_t;

  // per-box micro program: loads, 3x3 rotate, clamp, face, squares, finish
  function automatic step_dec_t decode_step(input logic [4:0] step);
    step_dec_t d;
    d = '{op: OP_NOP, i: 2'd0, j: 2'd0};
    case (step)
      5'd0:  d = '{op: OP_LD,    i: 2'd0, j: 2'd0};
      5'd1:  d = '{op: OP_LD,    i: 2'd1, j: 2'd0};
      5'd2:  d = '{op: OP_LD,    i: 2'd2, j: 2'd0};
      5'd3:  d = '{op: OP_MUL,   i: 2'd0, j: 2'd0};
      5'd4:  d = '{op: OP_MUL,   i: 2'd0, j: 2'd1};
      5'd5:  d = '{op: OP_MUL,   i: 2'd0, j: 2'd2};
      5'd6:  d = '{op: OP_MUL,   i: 2'd1, j: 2'd0};
      5'd7:  d = '{op: OP_MUL,   i: 2'd1, j: 2'd1};
      5'd8:  d = '{op: OP_MUL,   i: 2'd1, j: 2'd2};
      5'd9:  d = '{op: OP_MUL,   i: 2'd2, j: 2'd0};
      5'd10: d = '{op: OP_MUL,   i: 2'd2, j: 2'd1};
      5'd11: d = '{op: OP_MUL,   i: 2'd2, j: 2'd2};
      5'd13: d = '{op: OP_CLAMP, i: 2'd0, j: 2'd0};
      5'd14: d = '{op: OP_FACE,  i: 2'd0, j: 2'd0};
      5'd15: d = '{op: OP_SQ,    i: 2'd0, j: 2'd0};
      5'd16: d = '{op: OP_SQ,    i: 2'd1, j: 2'd0};
      5'd17: d = '{op: OP_SQ,    i: 2'd2, j: 2'd0};
      5'd20: d = '{op: OP_FIN,   i: 2'd0, j: 2'd0};
      default: d = '{op: OP_NOP, i: 2'd0, j: 2'd0};
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/obsd_sqrt.sv */
// Iterative 64-bit integer square root, two radicand bits per cycle.
// Depends on nothing; instantiated by obsd_dp.
module obsd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  input  logic        ack,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [35:0] rem;
  logic [4:0]  cnt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem[33:0], rad[63:62]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[30:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (ack) begin
      done <= 1'b0;
    end
  end

endmodule

/* hw/rtl/obsd_dp.sv */
// Datapath: box stores, shared multiplier, clamp/face logic, square root, output register.
// Depends on obsd_pkg and obsd_sqrt.
module obsd_dp #(
  parameter int MAX_BOXES = 16,
  parameter int BW        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  obsd_pkg::ctrl_cmd_t cmd,
  input  logic [BW-1:0]     box,
  input  obsd_pkg::in_word_t  in_data,
  input  logic [31:0]       threshold,
  input  logic              out_stall,
  output logic              out_valid,
  output obsd_pkg::out_word_t out_data,
  output obsd_pkg::dp_status_t status
);

  localparam int CDEPTH = 3 * MAX_BOXES;
  localparam int RDEPTH = 9 * MAX_BOXES;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int RAW    = $clog2(RDEPTH);

  logic [31:0] center_mem [CDEPTH];
  logic [31:0] size_mem   [CDEPTH];
  logic [31:0] rot_mem    [RDEPTH];

  logic [31:0] center_rd, size_rd, rot_rd;
  logic [CAW-1:0] c_waddr, c_raddr;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic slot_ok, wr_center, wr_size, wr_rot;

  obsd_pkg::ctrl_cmd_t cmd_q;

  logic signed [31:0] p [3];
  logic signed [32:0] d [3];
  logic signed [31:0] h [3];
  logic signed [36:0] loc [3];
  logic signed [37:0] cl [3];
  logic signed [37:0] lo [3];
  logic signed [37:0] hi [3];
  logic signed [37:0] e [3];
  logic in_box;

  logic signed [66:0] prod;
  logic        acc_en, acc_sq, acc_first;
  logic [1:0]  acc_i;
  logic [65:0] s;
  logic        sat_m, zero_f, sat_f;

  // write port: box words from write commands
  assign slot_ok = (32'(in_data.box_slot) < MAX_BOXES)
                && (in_data.word_select <= obsd_pkg::WSEL_LAST);
  assign wr_center = cmd.write_word && slot_ok && (in_data.word_select < obsd_pkg::WSEL_SIZE0);
  assign wr_size   = cmd.write_word && slot_ok && (in_data.word_select >= obsd_pkg::WSEL_SIZE0)
                  && (in_data.word_select < obsd_pkg::WSEL_ROT0);
  assign wr_rot    = cmd.write_word && slot_ok && (in_data.word_select >= obsd_pkg::WSEL_ROT0);
  assign c_waddr = CAW'(CAW'(in_data.box_slot) * CAW'(3)
                 + CAW'(wr_size ? in_data.word_select - obsd_pkg::WSEL_SIZE0
                                : in_data.word_select));
  assign r_waddr = RAW'(RAW'(in_data.box_slot) * RAW'(9)
                 + RAW'(in_data.word_select - obsd_pkg::WSEL_ROT0));
  assign c_raddr = CAW'(CAW'(box) * CAW'(3) + CAW'(cmd.i));
  assign r_raddr = RAW'(RAW'(box) * RAW'(9) + RAW'(cmd.j) * RAW'(3) + RAW'(cmd.i));

  always_ff @(posedge clk) begin
    if (wr_center) center_mem[c_waddr] <= in_data.word_value;
    if (wr_size)   size_mem[c_waddr]   <= in_data.word_value;
    if (wr_rot)    rot_mem[r_waddr]    <= in_data.word_value;
    center_rd <= center_mem[c_raddr];
    size_rd   <= size_mem[c_raddr];
    rot_rd    <= rot_mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) cmd_q <= '0;
    else     cmd_q <= cmd;
  end

  // shared multiplier: rotation x offset, or |e| squared
  logic signed [32:0] ma;
  logic signed [33:0] mb;
  logic signed [66:0] prod_c;
  logic signed [37:0] e_sel;
  logic [37:0] e_abs;

  always_comb begin
    e_sel = e[cmd_q.i];
    e_abs = e_sel[37] ? 38'(-e_sel) : 38'(e_sel);
    if (cmd_q.op == obsd_pkg::OP_SQ) begin
      ma = {1'b0, e_abs[31:0]};
      mb = {2'b00, e_abs[31:0]};
    end else begin
      ma = {rot_rd[31], rot_rd};
      mb = {d[cmd_q.j][32], d[cmd_q.j]};
    end
    prod_c = ma * mb;
  end

  // clamp to the box and the face distances
  logic signed [37:0] lx [3], hx [3], c1 [3], c2 [3];
  logic in_c;
  always_comb begin
    in_c = 1'b1;
    for (int k = 0; k < 3; k++) begin
      lx[k] = 38'(loc[k]);
      hx[k] = 38'(h[k]);
      c1[k] = (lx[k] < hx[k]) ? lx[k] : hx[k];
      c2[k] = (c1[k] < -hx[k]) ? -hx[k] : c1[k];
      if (c2[k] != lx[k]) in_c = 1'b0;
    end
  end

  // nearest face for an inside point, ties in x-,x+,y-,y+,z-,z+ order
  logic signed [37:0] best, cf [3];
  logic [1:0] face;
  logic plus;
  always_comb begin
    best = lo[0];
    face = 2'd0;
    plus = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (k != 0 && lo[k] < best) begin
        best = lo[k]; face = 2'(k); plus = 1'b0;
      end
      if (hi[k] < best) begin
        best = hi[k]; face = 2'(k); plus = 1'b1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      cf[k] = cl[k];
      if (in_box && face == 2'(k)) cf[k] = plus ? 38'(h[k]) : -38'(h[k]);
    end
  end

  logic signed [66:0] rnd;
  assign rnd = prod + 67'sd268435456;

  logic        sq_start, sq_busy, sq_done, load, load_box;
  logic [31:0] sq_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en <= 1'b0;
    end else begin
      acc_en <= (cmd_q.op == obsd_pkg::OP_MUL) || (cmd_q.op == obsd_pkg::OP_SQ);
    end
    acc_sq    <= (cmd_q.op == obsd_pkg::OP_SQ);
    acc_i     <= cmd_q.i;
    acc_first <= (cmd_q.op == obsd_pkg::OP_SQ) ? (cmd_q.i == 2'd0) : (cmd_q.j == 2'd0);
    prod      <= prod_c;

    if (cmd.start_query) begin
      p[0] <= in_data.point_x;
      p[1] <= in_data.point_y;
      p[2] <= in_data.point_z;
    end

    case (cmd_q.op)
      obsd_pkg::OP_LD: begin
        d[cmd_q.i] <= 33'(p[cmd_q.i]) - 33'($signed(center_rd));
        h[cmd_q.i] <= size_rd;
      end
      obsd_pkg::OP_CLAMP: begin
        in_box <= in_c;
        for (int k = 0; k < 3; k++) begin
          cl[k] <= c2[k];
          lo[k] <= lx[k] + hx[k];
          hi[k] <= hx[k] - lx[k];
        end
      end
      obsd_pkg::OP_FACE: begin
        for (int k = 0; k < 3; k++) e[k] <= lx[k] - cf[k];
      end
      obsd_pkg::OP_SQ: begin
        sat_m <= ((cmd_q.i == 2'd0) ? 1'b0 : sat_m) | (e_abs[37:32] != 6'd0);
      end
      obsd_pkg::OP_FIN: begin
        sat_f  <= sat_m || (s[65:64] != 2'd0);
        zero_f <= !sat_m && (s[65:64] == 2'd0) && (s[63:0] <= {14'd0, threshold, 18'd0});
      end
      default: ;
    endcase

    if (acc_en) begin
      if (acc_sq) s <= (acc_first ? 66'd0 : s) + {2'b00, prod[63:0]};
      else loc[acc_i] <= (acc_first ? 37'sd0 : loc[acc_i]) + rnd[65:29];
    end
  end

  assign sq_start = (cmd_q.op == obsd_pkg::OP_FIN);

  obsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (s[63:0]),
    .ack      (load_box),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // result and running minimum
  logic signed [31:0] mag, dval, min_d, min_n;
  logic [BW-1:0] min_b, min_bn;

  always_comb begin
    mag  = sat_f ? obsd_pkg::SAT_MAX : $signed({1'b0, sq_root[31:1]});
    dval = zero_f ? 32'sd0 : (in_box ? -mag : mag);
    min_n  = min_d;
    min_bn = min_b;
    if (dval < min_d) begin
      min_n  = dval;
      min_bn = box;
    end
  end

  assign load     = (sq_done || cmd.emit_empty) && (!out_valid || !out_stall);
  assign load_box = load && !cmd.emit_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.start_query) begin
      min_d <= obsd_pkg::SAT_MAX;
      min_b <= '0;
    end else if (load_box) begin
      min_d <= min_n;
      min_b <= min_bn;
    end
    if (load) begin
      if (cmd.emit_empty) begin
        out_data <= '{result_box: 4'd0, distance: 32'sd0, is_last: 1'b1,
                      min_distance: obsd_pkg::SAT_MAX, min_box: 4'd0, no_boxes: 1'b1};
      end else begin
        out_data <= '{result_box: 4'(box), distance: dval, is_last: cmd.is_last,
                      min_distance: min_n, min_box: 4'(min_bn), no_boxes: 1'b0};
      end
    end
  end

  assign status.wrote     = load;
  assign status.sqrt_busy = sq_busy;

endmodule

/* hw/rtl/obsd_ctrl.sv */
// Controller: input handshake, box loop and per-box micro program sequencing.
// Depends on obsd_pkg.
module obsd_ctrl #(
  parameter int MAX_BOXES = 16,
  parameter int BW        = 4,
  parameter int CW        = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic [4:0]          active_boxes,
  input  obsd_pkg::dp_status_t status,
  output logic                in_stall,
  output obsd_pkg::ctrl_cmd_t  cmd,
  output logic [BW-1:0]       box
);

  obsd_pkg::state_t state, state_next;
  logic [4:0]    step, step_next;
  logic [BW-1:0] box_next;
  logic [CW-1:0] n, n_next, n_cfg;
  logic          accept, last;
  obsd_pkg::step_dec_t dec;

  assign n_cfg  = (32'(active_boxes) > MAX_BOXES) ? CW'(MAX_BOXES) : CW'(active_boxes);
  assign accept = in_valid && (state == obsd_pkg::ST_IDLE);
  assign last   = (CW'(box) + CW'(1)) == n;
  assign dec    = obsd_pkg::decode_step(step);
  assign in_stall = (state != obsd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obsd_pkg::ST_IDLE;
      step  <= '0;
      box   <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      box   <= box_next;
      n     <= n_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    box_next   = box;
    n_next     = n;
    cmd        = '0;
    cmd.op     = obsd_pkg::OP_NOP;
    cmd.is_last = last;
    case (state)
      obsd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == obsd_pkg::CMD_WRITE) begin
            cmd.write_word = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            n_next   = n_cfg;
            box_next = '0;
            step_next = '0;
            state_next = (n_cfg == '0) ? obsd_pkg::ST_EMPTY : obsd_pkg::ST_RUN;
          end
        end
      end
      obsd_pkg::ST_EMPTY: begin
        cmd.emit_empty = 1'b1;
        cmd.is_last    = 1'b1;
        if (status.wrote) state_next = obsd_pkg::ST_IDLE;
      end
      obsd_pkg::ST_RUN: begin
        cmd.op = dec.op;
        cmd.i  = dec.i;
        cmd.j  = dec.j;
        step_next = step + 5'd1;
        if (step == obsd_pkg::LAST_STEP) state_next = obsd_pkg::ST_WAIT;
      end
      obsd_pkg::ST_WAIT: begin
        if (status.wrote) begin
          if (last) begin
            state_next = obsd_pkg::ST_IDLE;
          end else begin
            box_next   = box + BW'(1);
            step_next  = '0;
            state_next = obsd_pkg::ST_RUN;
          end
        end
      end
      default: state_next = obsd_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/oriented_box_signed_distance.sv */
// Oriented box signed distance: box table plus per-query distance sweep.
// Write word: accepted while idle, no result. Query: per box, a 21-step micro program on the
// shared multiplier, then the iterative square root, then the hand-off to the output register;
// one result word per active box; with no boxes, a single word with no_boxes set.
// One query at a time; input is stalled until the last result is in the output register.
// Reset (rst, synchronous) clears control and config; box stores are not cleared.
module oriented_box_signed_distance #(
  parameter int MAX_BOXES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  obsd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output obsd_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  // box index and box count widths
  localparam int BW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  // config registers
  logic [4:0]  active_boxes;
  logic [31:0] zero_threshold_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_boxes      <= '0;
      zero_threshold_sq <= '0;
    end else if (cfg_we) begin
      if (cfg_index == obsd_pkg::CFG_ACTIVE) active_boxes <= cfg_data[4:0];
      else                                   zero_threshold_sq <= cfg_data;
    end
  end

  obsd_pkg::ctrl_cmd_t  cmd;
  obsd_pkg::dp_status_t status;
  logic [BW-1:0]        box;

  // sequencer: handshake, box loop, micro program
  obsd_ctrl #(.MAX_BOXES(MAX_BOXES), .BW(BW), .CW(CW)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_cmd       (in_data.cmd),
    .active_boxes (active_boxes),
    .status       (status),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .box          (box)
  );

  // stores, arithmetic and output word register
  obsd_dp #(.MAX_BOXES(MAX_BOXES), .BW(BW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .box       (box),
    .in_data   (in_data),
    .threshold (zero_threshold_sq),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  // the running minimum never exceeds the distance it came with
  a_min_le_dist: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.no_boxes) |-> (out_data.min_distance <= out_data.distance))
    else $error("min_distance above distance");

  // the empty-query word is always the last one
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.no_boxes) |-> out_data.is_last)
    else $error("no_boxes word without is_last");

  // a write word never holds the input off
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.cmd == obsd_pkg::CMD_WRITE)) |=> !in_stall)
    else $error("stall after write word");

endmodule
